@@ src/rbad_pkg.sv @@
// Shared types, constants and codes of the RGBA box-average downscaler.
`default_nettype none
package rbad_pkg;

	localparam int SIZE_W            = 14;
	localparam int CH_W              = 8;
	localparam int SUM_W             = 34;
	localparam int CNT_W             = 27;
	localparam int PROD_W            = 2 * SIZE_W;
	localparam int CFG_IDX_W         = 2;
	localparam int AVG_STEPS         = CH_W;
	localparam int DIM_STEPS         = SIZE_W;
	localparam int STEP_W            = 4;
	localparam int DEF_MAX_IMAGE_DIM = 8192;
	localparam logic [SIZE_W-1:0] RST_SRC_W = SIZE_W'(1);
	localparam logic [SIZE_W-1:0] RST_SRC_H = SIZE_W'(1);
	localparam logic [SIZE_W-1:0] RST_MAX_W = SIZE_W'(3840);
	localparam logic [SIZE_W-1:0] RST_MAX_H = SIZE_W'(2560);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_W,
		REG_SRC_H,
		REG_MAX_W,
		REG_MAX_H
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0]   red_out;
		logic [CH_W-1:0]   green_out;
		logic [CH_W-1:0]   blue_out;
		logic [CH_W-1:0]   alpha_out;
		logic [SIZE_W-1:0] dest_width;
		logic [SIZE_W-1:0] dest_height;
		logic              image_done;
	} pix_out_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SCALE_A,
		OP_SCALE_B,
		OP_SCALE_C,
		OP_DIM_LOAD,
		OP_DIM_STEP,
		OP_ACCEPT,
		OP_UPDATE,
		OP_AVG_STEP,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sel_h;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic last_box;
		logic out_free;
	} dp_status_t;

	typedef enum logic [3:0] {
		S_SCALE_A,
		S_SCALE_B,
		S_SCALE_C,
		S_DIM_LOAD,
		S_DIM_DIV,
		S_IDLE,
		S_UPDATE,
		S_AVG,
		S_OUT
	} ctl_state_t;

endpackage
`default_nettype wire

@@ src/rbad_ctrl.sv @@
// Controller state machine sequencing scale setup, accumulation and averaging.
`default_nettype none
module rbad_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  rbad_pkg::dp_status_t     status,
	output rbad_pkg::dp_cmd_t        cmd
);
	import rbad_pkg::*;

	ctl_state_t          state_q, state_nxt;
	logic                sel_h_q, sel_h_nxt;
	logic [STEP_W-1:0]   cnt_q, cnt_nxt;

	// State, step counter and dimension select registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SCALE_A;
			sel_h_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			sel_h_q <= sel_h_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		sel_h_nxt = sel_h_q;
		cnt_nxt   = cnt_q;
		cmd.op    = OP_NONE;
		cmd.sel_h = sel_h_q;
		cmd.last  = 1'b0;
		in_stall  = 1'b1;
		case (state_q)
			S_SCALE_A: begin
				cmd.op    = OP_SCALE_A;
				state_nxt = S_SCALE_B;
			end
			S_SCALE_B: begin
				cmd.op    = OP_SCALE_B;
				state_nxt = S_SCALE_C;
			end
			S_SCALE_C: begin
				cmd.op    = OP_SCALE_C;
				sel_h_nxt = 1'b0;
				state_nxt = S_DIM_LOAD;
			end
			S_DIM_LOAD: begin
				cmd.op    = OP_DIM_LOAD;
				cnt_nxt   = '0;
				state_nxt = S_DIM_DIV;
			end
			S_DIM_DIV: begin
				cmd.op  = OP_DIM_STEP;
				cnt_nxt = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIM_STEPS - 1)) begin
					cmd.last = 1'b1;
					if (sel_h_q) begin
						state_nxt = S_IDLE;
					end else begin
						sel_h_nxt = 1'b1;
						state_nxt = S_DIM_LOAD;
					end
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op    = OP_ACCEPT;
					state_nxt = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.op  = OP_UPDATE;
				cnt_nxt = '0;
				state_nxt = status.last_box ? S_AVG : S_IDLE;
			end
			S_AVG: begin
				cmd.op  = OP_AVG_STEP;
				cnt_nxt = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(AVG_STEPS - 1)) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.op    = OP_OUT_LOAD;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_SCALE_A;
			end
		endcase
		// A register write restarts the scale computation and the image.
		if (cfg_we) begin
			state_nxt = S_SCALE_A;
		end
	end

endmodule
`default_nettype wire

@@ src/rbad_datapath.sv @@
// Datapath: configuration, scale and size arithmetic, column store and averaging.
`default_nettype none
module rbad_datapath #(
	parameter int MAX_IMAGE_DIM = rbad_pkg::DEF_MAX_IMAGE_DIM
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rbad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rbad_pkg::SIZE_W-1:0]       cfg_data,
	input  rbad_pkg::pix_in_t                      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output rbad_pkg::pix_out_t                     out_data,
	input  rbad_pkg::dp_cmd_t                      cmd,
	output rbad_pkg::dp_status_t                   status
);
	import rbad_pkg::*;

	localparam int COL_W = $clog2(MAX_IMAGE_DIM);
	localparam logic [SIZE_W:0] MAX_LIM = (SIZE_W + 1)'(MAX_IMAGE_DIM);

	typedef struct packed {
		logic [3:0][SUM_W-1:0] sum;
		logic [CNT_W-1:0]      cnt;
	} col_entry_t;

	function automatic logic [SIZE_W-1:0] eff_src(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if ({1'b0, v} > MAX_LIM) begin
			r = MAX_LIM[SIZE_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] eff_max(input logic [SIZE_W-1:0] v);
		return (v == '0) ? SIZE_W'(1) : v;
	endfunction

	// Configuration and derived image geometry.
	logic [SIZE_W-1:0] src_w_q, src_h_q, max_w_q, max_h_q;
	logic [SIZE_W-1:0] sw_q, sh_q, mh_q, mul_q, dv_q, dw_q, dh_q;
	logic [PROD_W-1:0] prod_a_s1, prod_b_s1;
	logic [PROD_W-1:0] rem_q, dsh_q;
	logic [SIZE_W-1:0] quo_q, quo_nxt;
	logic              dim_ge;
	logic [SIZE_W-1:0] esw, esh, emw;

	// Source position and box tracking.
	logic [SIZE_W-1:0] x_q, y_q, rx_q, ry_q;
	logic [COL_W-1:0]  dx_q;
	logic [SIZE_W:0]   rx_sum, ry_sum;
	logic              last_x, last_y, first_col, first_row, last_col, last_row;

	// Column store and pipeline.
	col_entry_t        col_mem_q [MAX_IMAGE_DIM];
	col_entry_t        rd_s1, new_entry;
	pix_in_t           pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic              first_s1, last_s1, done_s1;
	logic [3:0][CH_W-1:0] chan_s1;

	// Averaging divider.
	logic [3:0][SUM_W-1:0] arem_q;
	logic [SUM_W-1:0]      adsh_q;
	logic [3:0][CH_W-1:0]  aq_q;

	pix_out_t out_q;
	logic     out_valid_q;

	assign esw = eff_src(src_w_q);
	assign esh = eff_src(src_h_q);
	assign emw = eff_max(max_w_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SRC_W;
			src_h_q <= RST_SRC_H;
			max_w_q <= RST_MAX_W;
			max_h_q <= RST_MAX_H;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_W: src_w_q <= cfg_data;
				REG_SRC_H: src_h_q <= cfg_data;
				REG_MAX_W: max_w_q <= cfg_data;
				REG_MAX_H: max_h_q <= cfg_data;
				default:   src_w_q <= src_w_q;
			endcase
		end
	end

	// One restoring step of the destination size divider.
	always_comb begin
		dim_ge  = rem_q >= dsh_q;
		quo_nxt = {quo_q[SIZE_W-2:0], dim_ge};
	end

	// Scale fraction, destination size and divider registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SCALE_A: begin
				sw_q <= esw;
				sh_q <= esh;
				mh_q <= eff_max(max_h_q);
				if (esw > emw) begin
					mul_q <= emw;
					dv_q  <= esw;
				end else begin
					mul_q <= SIZE_W'(1);
					dv_q  <= SIZE_W'(1);
				end
			end
			OP_SCALE_B: begin
				prod_a_s1 <= PROD_W'(mul_q) * PROD_W'(sh_q);
				prod_b_s1 <= PROD_W'(mh_q) * PROD_W'(dv_q);
			end
			OP_SCALE_C: begin
				if (prod_a_s1 > prod_b_s1) begin
					mul_q <= mh_q;
					dv_q  <= sh_q;
				end
			end
			OP_DIM_LOAD: begin
				rem_q <= PROD_W'(cmd.sel_h ? sh_q : sw_q) * PROD_W'(mul_q)
					+ PROD_W'(dv_q) - PROD_W'(1);
				dsh_q <= PROD_W'(dv_q) << (DIM_STEPS - 1);
				quo_q <= '0;
			end
			OP_DIM_STEP: begin
				if (dim_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nxt;
				if (cmd.last) begin
					if (cmd.sel_h) begin
						dh_q <= quo_nxt;
					end else begin
						dw_q <= quo_nxt;
					end
				end
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

	// Box edges follow from the running remainders of x*dW/sW and y*dH/sH.
	always_comb begin
		rx_sum    = {1'b0, rx_q} + {1'b0, dw_q};
		ry_sum    = {1'b0, ry_q} + {1'b0, dh_q};
		last_x    = ({1'b0, x_q} + 1'b1) == {1'b0, sw_q};
		last_y    = ({1'b0, y_q} + 1'b1) == {1'b0, sh_q};
		first_col = rx_q < dw_q;
		first_row = ry_q < dh_q;
		last_col  = last_x || (rx_sum >= {1'b0, sw_q});
		last_row  = last_y || (ry_sum >= {1'b0, sh_q});
	end

	// Raster position, advanced on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			rx_q <= '0;
			ry_q <= '0;
			dx_q <= '0;
		end else if (cmd.op == OP_SCALE_A) begin
			x_q  <= '0;
			y_q  <= '0;
			rx_q <= '0;
			ry_q <= '0;
			dx_q <= '0;
		end else if (cmd.op == OP_ACCEPT) begin
			if (last_x) begin
				x_q  <= '0;
				rx_q <= '0;
				dx_q <= '0;
				if (last_y) begin
					y_q  <= '0;
					ry_q <= '0;
				end else begin
					y_q  <= y_q + 1'b1;
					ry_q <= (ry_sum >= {1'b0, sh_q}) ? SIZE_W'(ry_sum - {1'b0, sh_q})
						: ry_sum[SIZE_W-1:0];
				end
			end else begin
				x_q <= x_q + 1'b1;
				if (rx_sum >= {1'b0, sw_q}) begin
					rx_q <= SIZE_W'(rx_sum - {1'b0, sw_q});
					dx_q <= dx_q + 1'b1;
				end else begin
					rx_q <= rx_sum[SIZE_W-1:0];
				end
			end
		end
	end

	// Incoming channels as a small array, and the updated column entry.
	always_comb begin
		chan_s1[0] = pix_s1.red_in;
		chan_s1[1] = pix_s1.green_in;
		chan_s1[2] = pix_s1.blue_in;
		chan_s1[3] = pix_s1.alpha_in;
		for (int i = 0; i < 4; i++) begin
			new_entry.sum[i] = first_s1 ? SUM_W'(chan_s1[i])
				: rd_s1.sum[i] + SUM_W'(chan_s1[i]);
		end
		new_entry.cnt = first_s1 ? CNT_W'(1) : rd_s1.cnt + 1'b1;
	end

	// Column store: read on transfer, write back in the following cycle.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT) begin
			rd_s1    <= col_mem_q[dx_q];
			pix_s1   <= in_data;
			col_s1   <= dx_q;
			first_s1 <= first_col && first_row;
			last_s1  <= last_col && last_row;
			done_s1  <= last_x && last_y;
		end
		if (cmd.op == OP_UPDATE) begin
			col_mem_q[col_s1] <= new_entry;
		end
	end

	// Averaging: one quotient bit per cycle for all four channels.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_UPDATE) begin
			arem_q <= new_entry.sum;
			adsh_q <= SUM_W'(new_entry.cnt) << (AVG_STEPS - 1);
			aq_q   <= '0;
		end else if (cmd.op == OP_AVG_STEP) begin
			for (int i = 0; i < 4; i++) begin
				if (arem_q[i] >= adsh_q) begin
					arem_q[i] <= arem_q[i] - adsh_q;
				end
				aq_q[i] <= {aq_q[i][CH_W-2:0], arem_q[i] >= adsh_q};
			end
			adsh_q <= adsh_q >> 1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT_LOAD) begin
			out_q.red_out     <= aq_q[0];
			out_q.green_out   <= aq_q[1];
			out_q.blue_out    <= aq_q[2];
			out_q.alpha_out   <= aq_q[3];
			out_q.dest_width  <= dw_q;
			out_q.dest_height <= dh_q;
			out_q.image_done  <= done_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign status.last_box = last_s1;
	assign status.out_free = !out_valid_q || !out_stall;

	// The destination size never exceeds the source size and is never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACCEPT) |-> (dw_q != '0 && dw_q <= sw_q && dh_q != '0 && dh_q <= sh_q))
		else $error("destination size out of range");

	// The raster position and box remainders stay inside the source image.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACCEPT) |-> (x_q < sw_q && y_q < sh_q && rx_q < sw_q && ry_q < sh_q))
		else $error("source position out of range");

	// An averaged box always holds at least one pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_UPDATE) |=> (adsh_q != '0))
		else $error("empty box reached the averaging divider");

endmodule
`default_nettype wire

@@ src/rgba_box_average_downscaler_unit.sv @@
// Top level of the RGBA box-average downscaler.
`default_nettype none
// Source pixels enter in raster order; each one is read from, summed into and
// written back to its destination column entry, so the rate of pixels that do
// not close a box is bounded by the single read-modify-write port of the
// column store. A pixel that closes a box also takes accumulation, eight
// restoring division steps for the four averages and an output load, plus any
// wait for the output register; input is stalled meanwhile. After reset and
// after every register write the scale fraction and both destination sizes
// are worked out while input is stalled. The column store needs no clearing pass.
module rgba_box_average_downscaler_unit #(
	parameter int MAX_IMAGE_DIM = rbad_pkg::DEF_MAX_IMAGE_DIM
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rbad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rbad_pkg::SIZE_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  rbad_pkg::pix_in_t                      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output rbad_pkg::pix_out_t                     out_data
);
	import rbad_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer.
	rbad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and storage.
	rbad_datapath #(
		.MAX_IMAGE_DIM (MAX_IMAGE_DIM)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the RGBA box-average downscaler top level.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rbad_pkg::*;

	typedef enum logic [1:0] {
		ACT_PIXEL,
		ACT_WRITE,
		ACT_SETTLE
	} action_kind_t;

	typedef struct {
		action_kind_t kind;
		cfg_reg_t     index;
		logic [13:0]  value;
		pix_in_t      pixel;
	} action_t;

	localparam int DIM     = DEF_MAX_IMAGE_DIM;
	localparam int SETTLE  = 24;
	localparam int HOLDOFF = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]  cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	pix_in_t            in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	pix_out_t           out_data;

	rgba_box_average_downscaler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Free-running clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	action_t  pending_actions[$];
	pix_out_t expected_pixels[$];
	int       pixels_sent = 0;
	int       errors = 0;

	// Shadow of the registers, the scale and the column accumulators.
	logic [13:0] reg_src_w = 14'd1, reg_src_h = 14'd1;
	logic [13:0] reg_max_w = 14'd3840, reg_max_h = 14'd2560;
	longint unsigned scale_mul = 1, scale_div = 1;
	int unsigned pos_x = 0, pos_y = 0;
	logic [SUM_W-1:0] col_sum[4][DIM];
	logic [CNT_W-1:0] col_count[DIM];

	function automatic longint unsigned clamp_src(logic [13:0] v);
		if (v == 0) return 1;
		if (v > DIM) return DIM;
		return v;
	endfunction

	function automatic longint unsigned clamp_max(logic [13:0] v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic longint unsigned scaled_size(longint unsigned s);
		return (s * scale_mul + scale_div - 1) / scale_div;
	endfunction

	function automatic longint unsigned box_index(longint unsigned p, longint unsigned d,
			longint unsigned s);
		return (p * d) / s;
	endfunction

	// Register write: recompute the scale and restart the image.
	task automatic apply_register(cfg_reg_t idx, logic [13:0] v);
		longint unsigned sw, sh, mw, mh;
		case (idx)
			REG_SRC_W: reg_src_w = v;
			REG_SRC_H: reg_src_h = v;
			REG_MAX_W: reg_max_w = v;
			REG_MAX_H: reg_max_h = v;
			default: ;
		endcase
		sw = clamp_src(reg_src_w);
		sh = clamp_src(reg_src_h);
		mw = clamp_max(reg_max_w);
		mh = clamp_max(reg_max_h);
		scale_mul = 1;
		scale_div = 1;
		if (scale_mul * sw > mw * scale_div) begin
			scale_mul = mw;
			scale_div = sw;
		end
		if (scale_mul * sh > mh * scale_div) begin
			scale_mul = mh;
			scale_div = sh;
		end
		pos_x = 0;
		pos_y = 0;
	endtask

	// Accumulate one source pixel and queue the box average it completes.
	task automatic accumulate_pixel(pix_in_t p);
		longint unsigned sw, sh, dw, dh, x, y, dx, dy, c;
		logic first_c, first_r, last_c, last_r;
		logic [7:0] ch[4];
		pix_out_t res;
		sw = clamp_src(reg_src_w);
		sh = clamp_src(reg_src_h);
		dw = scaled_size(sw);
		dh = scaled_size(sh);
		if (dw == 0) dw = 1;
		if (dh == 0) dh = 1;
		x = (pos_x >= sw) ? 0 : pos_x;
		y = (pos_y >= sh) ? 0 : pos_y;
		dx = box_index(x, dw, sw);
		dy = box_index(y, dh, sh);
		first_c = (x == 0) || box_index(x - 1, dw, sw) != dx;
		first_r = (y == 0) || box_index(y - 1, dh, sh) != dy;
		last_c = (x + 1 == sw) || box_index(x + 1, dw, sw) != dx;
		last_r = (y + 1 == sh) || box_index(y + 1, dh, sh) != dy;
		c = (dx < DIM) ? dx : DIM - 1;
		ch[0] = p.red_in;
		ch[1] = p.green_in;
		ch[2] = p.blue_in;
		ch[3] = p.alpha_in;
		for (int k = 0; k < 4; k++)
			col_sum[k][c] = (first_c && first_r) ? SUM_W'(ch[k]) : col_sum[k][c] + ch[k];
		col_count[c] = (first_c && first_r) ? CNT_W'(1) : col_count[c] + 1'b1;
		if (x + 1 >= sw) begin
			pos_x = 0;
			pos_y = (y + 1 >= sh) ? 0 : y + 1;
		end else begin
			pos_x = x + 1;
			pos_y = y;
		end
		if (last_c && last_r) begin
			res.red_out     = (col_count[c] == 0) ? 8'd0 : 8'(col_sum[0][c] / col_count[c]);
			res.green_out   = (col_count[c] == 0) ? 8'd0 : 8'(col_sum[1][c] / col_count[c]);
			res.blue_out    = (col_count[c] == 0) ? 8'd0 : 8'(col_sum[2][c] / col_count[c]);
			res.alpha_out   = (col_count[c] == 0) ? 8'd0 : 8'(col_sum[3][c] / col_count[c]);
			res.dest_width  = SIZE_W'(dw);
			res.dest_height = SIZE_W'(dh);
			res.image_done  = (x + 1 == sw) && (y + 1 == sh);
			expected_pixels.insert(expected_pixels.size(), res);
		end
	endtask

	// Sender idling percentage for the current stage of the run.
	function automatic int sender_idle_pct();
		if (pixels_sent < 550) return 15;
		if (pixels_sent < 1100) return 45;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (pixels_sent < 550) return 45;
		if (pixels_sent < 1100) return 15;
		return 0;
	endfunction

	// Driver: works through the action queue one transfer at a time.
	int settle_count = 0;
	always @(posedge clk) begin
		logic    nxt_valid, nxt_we;
		pix_in_t nxt_data;
		nxt_valid = in_valid;
		nxt_we = 1'b0;
		nxt_data = in_data;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				accumulate_pixel(in_data);
				pixels_sent++;
				void'(pending_actions.pop_front());
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_actions.size() > 0) begin
				case (pending_actions[0].kind)
					ACT_PIXEL: begin
						if ($urandom_range(99) >= sender_idle_pct()) begin
							nxt_valid = 1'b1;
							nxt_data = pending_actions[0].pixel;
						end
					end
					ACT_WRITE: begin
						nxt_we = 1'b1;
						cfg_index <= pending_actions[0].index;
						cfg_data <= pending_actions[0].value;
						apply_register(pending_actions[0].index, pending_actions[0].value);
						void'(pending_actions.pop_front());
					end
					default: begin
						if (expected_pixels.size() == 0) begin
							settle_count++;
							if (settle_count >= SETTLE) begin
								settle_count = 0;
								void'(pending_actions.pop_front());
							end
						end
					end
				endcase
			end
		end
		in_valid <= nxt_valid;
		in_data <= nxt_data;
		cfg_we <= nxt_we;
	end

	// Monitor: checks each result transfer and drives the output stall.
	int  holdoff_left = 0;
	bit  holdoff_done = 1'b0;
	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("result transfer with nothing expected: %h", out_data);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (out_data.red_out !== want.red_out) begin
					$error("red_out expected %0d got %0d", want.red_out, out_data.red_out);
					errors++;
				end
				if (out_data.green_out !== want.green_out) begin
					$error("green_out expected %0d got %0d", want.green_out,
						out_data.green_out);
					errors++;
				end
				if (out_data.blue_out !== want.blue_out) begin
					$error("blue_out expected %0d got %0d", want.blue_out, out_data.blue_out);
					errors++;
				end
				if (out_data.alpha_out !== want.alpha_out) begin
					$error("alpha_out expected %0d got %0d", want.alpha_out,
						out_data.alpha_out);
					errors++;
				end
				if (out_data.dest_width !== want.dest_width) begin
					$error("dest_width expected %0d got %0d", want.dest_width,
						out_data.dest_width);
					errors++;
				end
				if (out_data.dest_height !== want.dest_height) begin
					$error("dest_height expected %0d got %0d", want.dest_height,
						out_data.dest_height);
					errors++;
				end
				if (out_data.image_done !== want.image_done) begin
					$error("image_done expected %0d got %0d", want.image_done,
						out_data.image_done);
					errors++;
				end
			end
		end
		// One long hold-off part way through, while the sender keeps offering.
		if (!holdoff_done && pixels_sent >= 1200) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_idle_pct());
		end
	end

	task automatic add_pixel(logic [31:0] v);
		action_t a;
		a.kind = ACT_PIXEL;
		a.index = REG_SRC_W;
		a.value = '0;
		a.pixel = v;
		pending_actions.insert(pending_actions.size(), a);
	endtask

	task automatic add_settle();
		action_t a;
		a.kind = ACT_SETTLE;
		a.index = REG_SRC_W;
		a.value = '0;
		a.pixel = '0;
		pending_actions.insert(pending_actions.size(), a);
	endtask

	// A settle always comes first so that writes land with the block idle.
	task automatic add_setup(logic [13:0] sw, logic [13:0] sh, logic [13:0] mw,
			logic [13:0] mh);
		action_t a;
		add_settle();
		a.kind = ACT_WRITE;
		a.pixel = '0;
		a.index = REG_SRC_W; a.value = sw; pending_actions.insert(pending_actions.size(), a);
		a.index = REG_SRC_H; a.value = sh; pending_actions.insert(pending_actions.size(), a);
		a.index = REG_MAX_W; a.value = mw; pending_actions.insert(pending_actions.size(), a);
		a.index = REG_MAX_H; a.value = mh; pending_actions.insert(pending_actions.size(), a);
	endtask

	function automatic logic [7:0] random_channel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Stimulus, reset and end of run.
	initial begin
		int queued, sw, sh, mw, mh, n;
		// Reset size 1x1: every pixel is its own box and ends the image.
		add_pixel(32'h0000_0000);
		add_pixel(32'hFFFF_FFFF);
		add_pixel(32'hA55A_3CC3);
		// Downscale 3x2 into 2x1 with extreme values.
		add_setup(14'd3, 14'd2, 14'd2, 14'd1);
		add_pixel(32'hFFFF_FFFF); add_pixel(32'h0000_0000); add_pixel(32'hFF00_FF00);
		add_pixel(32'hFFFF_FFFF); add_pixel(32'h00FF_00FF); add_pixel(32'h1234_5678);
		// Zero sizes act as one.
		add_setup(14'd0, 14'd0, 14'd0, 14'd0);
		add_pixel(32'h8081_7F7E); add_pixel(32'hFFFF_0000);
		// Widths beyond the store depth, partial image dropped by the next write.
		add_setup(14'h3FFF, 14'd1, 14'd24, 14'd8192);
		for (int i = 0; i < 600; i++)
			add_pixel({random_channel(), random_channel(), random_channel(), random_channel()});
		// A tall image squeezed to few rows, largest maximum width.
		add_setup(14'd2, 14'd9, 14'd8192, 14'd2);
		for (int i = 0; i < 18; i++)
			add_pixel($urandom);
		queued = 0;
		while (queued < 1070) begin
			sw = $urandom_range(1, 24);
			sh = $urandom_range(1, 12);
			mw = $urandom_range(1, sw + 4);
			mh = $urandom_range(1, sh + 4);
			if ($urandom_range(9) == 0) mw = 8192;
			if ($urandom_range(9) == 0) mh = 0;
			add_setup(14'(sw), 14'(sh), 14'(mw), 14'(mh));
			n = sw * sh * $urandom_range(1, 3);
			if ($urandom_range(4) == 0) n = $urandom_range(1, n);
			for (int i = 0; i < n; i++) begin
				add_pixel({random_channel(), random_channel(), random_channel(),
					random_channel()});
				if ($urandom_range(199) == 0) add_settle();
			end
			queued += n;
		end
		add_settle();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_actions.size() == 0 && !in_valid && expected_pixels.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("rgba_box_average_downscaler_unit: match");
		end else begin
			$display("rgba_box_average_downscaler_unit: mismatch");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#30ms;
		$display("rgba_box_average_downscaler_unit: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
